// ===== sv/nsva_pkg.sv =====
package nsva_pkg;

  localparam int SRC_SLOTS = 32;
  localparam int SLOT_W    = 5;
  localparam int VOICES    = 8;
  localparam int CHAN_W    = 3;
  localparam int VCNT_W    = 4;
  localparam int DIST_W    = 25;
  localparam int VOL_W     = 13;
  localparam int SQ_W      = 34;
  localparam int RANGE_W   = 16;
  localparam logic [RANGE_W-1:0] RANGE_RESET = 16'd1000;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_ADDED   = 3'd0,
    KIND_FULL    = 3'd1,
    KIND_DELETED = 3'd2,
    KIND_SETVOL  = 3'd3,
    KIND_START   = 3'd4,
    KIND_DONE    = 3'd5
  } kind_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               rep;
    logic [15:0]        sound;
  } src_entry_t;

  typedef struct packed {
    logic [CHAN_W-1:0]       chan;
    logic signed [VOL_W-1:0] vol;
  } dyn_entry_t;

endpackage

// ===== sv/nearest_source_voice_allocator.sv =====
// Channel        Dir  Width        Contents
// s_axis         in   80 + 2 user  add / delete / listener update commands
// m_axis         out  40 + 3 user  result transactions, tlast on the final one
// cfg            in   16           audible range write
//
// An update walks all 32 slots, one at a time: each used slot takes a memory
// read, three squarings, a 25-step square root and a 12-step divide in
// nsva_dist, an unused slot is skipped, and a start phase then pairs free
// channels with candidates. Reset is synchronous and clears the used and
// bound bits at once; no clearing pass is needed. A stalled m_axis holds the
// sequencer at the next result; s_tready is low until the command's last
// result is registered.
module nearest_source_voice_allocator
  import nsva_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // tdata: pos_x, pos_y, pos_z, slot, repeat_flag, sound_id, busy_channels
  input  logic [79:0]         s_tdata,
  // tuser: command
  input  logic [1:0]          s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // tdata: slot_index, channel, volume, sound_out
  output logic [39:0]         m_tdata,
  // tuser: kind
  output logic [2:0]          m_tuser,
  output logic                m_tlast,
  input  logic                cfg_we,
  input  logic [RANGE_W-1:0]  cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_DEL, S_U_RD, S_U_DIFF, S_U_MUL, S_U_DIST, S_U_WAIT,
    S_U_ACT, S_S_CHK, S_S_RD, S_S_EMIT, S_DONE
  } state_t;

  state_t state;

  logic [RANGE_W-1:0] audible_range;

  // latched command
  logic signed [15:0] in_x, in_y, in_z;
  logic [SLOT_W-1:0]  in_slot;
  logic               in_rep;
  logic [15:0]        in_sound;
  logic [VOICES-1:0]  busy;

  logic [SRC_SLOTS-1:0] used;
  logic [SRC_SLOTS-1:0] bound;

  // source and per-update memories
  src_entry_t src_mem [SRC_SLOTS];
  dyn_entry_t dyn_mem [SRC_SLOTS];
  src_entry_t src_rd;
  dyn_entry_t dyn_rd;
  logic       src_we;
  src_entry_t src_wdata;
  logic       dyn_we;
  dyn_entry_t dyn_wdata;

  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] free_idx;
  logic              any_free;

  logic signed [16:0] dx, dy, dz;
  logic signed [16:0] msel;
  logic signed [SQ_W-1:0] prod;
  logic [SQ_W-1:0]    acc;
  logic [1:0]         mcnt;

  logic                    dist_done;
  logic [DIST_W-1:0]       src_dist;
  logic signed [VOL_W-1:0] vol;

  logic [DIST_W-1:0] cand_dist [VOICES];
  logic [SLOT_W-1:0] cand_slot [VOICES];
  logic [VOICES-1:0] cand_valid;
  logic [VOICES-1:0] lt;
  logic [DIST_W-1:0] limit;

  logic [VCNT_W-1:0] ch;
  logic [VCNT_W-1:0] k;

  logic can_emit;
  logic emit;
  logic [SLOT_W-1:0]       o_slot;
  logic [CHAN_W-1:0]       o_chan;
  logic signed [VOL_W-1:0] o_vol;
  logic [15:0]             o_sound;

  assign s_tready = (state == S_IDLE);
  assign can_emit = !m_tvalid || m_tready;
  // a result transaction is loaded this cycle
  assign emit     = can_emit && ((state inside {S_ADD, S_DEL, S_S_EMIT, S_DONE}) ||
                    (state == S_U_ACT && bound[idx] && busy[dyn_rd.chan]));
  assign limit    = {1'b0, audible_range, 8'd0};
  assign m_tdata  = {3'd0, o_sound, o_vol, o_chan, o_slot};

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = SRC_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        any_free = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < VOICES; j++) lt[j] = src_dist < cand_dist[j];
  end

  always_comb begin
    case (mcnt)
      2'd0:    msel = dx;
      2'd1:    msel = dy;
      default: msel = dz;
    endcase
  end
  assign prod = msel * msel;

  // memory write ports
  always_comb begin
    src_we    = (state == S_ADD) && can_emit && any_free;
    src_wdata = '{x: in_x, y: in_y, z: in_z, rep: in_rep, sound: in_sound};
    dyn_we    = 1'b0;
    dyn_wdata = dyn_rd;
    if (state == S_U_ACT) begin
      dyn_we        = 1'b1;
      dyn_wdata.vol = vol;
    end else if (state == S_S_EMIT && can_emit) begin
      dyn_we         = 1'b1;
      dyn_wdata.chan = ch[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (src_we) src_mem[free_idx] <= src_wdata;
    if (dyn_we) dyn_mem[idx] <= dyn_wdata;
    src_rd <= src_mem[idx];
    dyn_rd <= dyn_mem[idx];
  end

  nsva_dist u_dist (
    .clk           (clk),
    .rst           (rst),
    .start         (state == S_U_DIST),
    .sq            (acc),
    .audible_range (audible_range),
    .done          (dist_done),
    .distance      (src_dist),
    .vol           (vol)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      audible_range <= RANGE_RESET;
      used          <= '0;
      bound         <= '0;
      m_tvalid      <= 1'b0;
      cand_valid    <= '0;
    end else begin
      if (cfg_we) audible_range <= cfg_wdata;
      // hold the result until taken, load a new one when emitting
      m_tvalid <= emit || (m_tvalid && !m_tready);

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_x     <= s_tdata[15:0];
            in_y     <= s_tdata[31:16];
            in_z     <= s_tdata[47:32];
            in_slot  <= s_tdata[52:48];
            in_rep   <= s_tdata[53];
            in_sound <= s_tdata[69:54];
            busy     <= s_tdata[77:70];
            idx      <= '0;
            case (cmd_t'(s_tuser))
              CMD_ADD:    state <= S_ADD;
              CMD_DELETE: state <= S_DEL;
              CMD_UPDATE: begin
                for (int j = 0; j < VOICES; j++) cand_dist[j] <= limit;
                cand_valid <= '0;
                state      <= S_U_RD;
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        S_ADD: begin
          if (can_emit) begin
            m_tlast  <= 1'b1;
            o_chan   <= '0;
            o_vol    <= '0;
            o_sound  <= '0;
            if (any_free) begin
              used[free_idx]  <= 1'b1;
              bound[free_idx] <= 1'b0;
              m_tuser         <= KIND_ADDED;
              o_slot          <= free_idx;
            end else begin
              m_tuser <= KIND_FULL;
              o_slot  <= '0;
            end
            state <= S_IDLE;
          end
        end

        S_DEL: begin
          if (can_emit) begin
            used[in_slot]  <= 1'b0;
            bound[in_slot] <= 1'b0;
            m_tlast  <= 1'b1;
            m_tuser  <= KIND_DELETED;
            o_slot   <= in_slot;
            o_chan   <= '0;
            o_vol    <= '0;
            o_sound  <= '0;
            state    <= S_IDLE;
          end
        end

        // walk slots; skip unused ones
        S_U_RD: begin
          if (used[idx]) begin
            state <= S_U_DIFF;
          end else if (idx == SLOT_W'(SRC_SLOTS - 1)) begin
            ch    <= '0;
            k     <= '0;
            state <= S_S_CHK;
          end else begin
            idx <= idx + SLOT_W'(1);
          end
        end

        S_U_DIFF: begin
          dx    <= 17'(in_x) - 17'(src_rd.x);
          dy    <= 17'(in_y) - 17'(src_rd.y);
          dz    <= 17'(in_z) - 17'(src_rd.z);
          acc   <= '0;
          mcnt  <= '0;
          state <= S_U_MUL;
        end

        S_U_MUL: begin
          acc  <= acc + prod;
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'd2) state <= S_U_DIST;
        end

        S_U_DIST: state <= S_U_WAIT;

        S_U_WAIT: begin
          if (dist_done) state <= S_U_ACT;
        end

        S_U_ACT: begin
          if (bound[idx] && busy[dyn_rd.chan]) begin
            // still playing: refresh volume
            if (can_emit) begin
              m_tlast  <= 1'b0;
              m_tuser  <= KIND_SETVOL;
              o_slot   <= idx;
              o_chan   <= dyn_rd.chan;
              o_vol    <= vol;
              o_sound  <= '0;
            end
          end else if (bound[idx]) begin
            bound[idx] <= 1'b0;
            if (!src_rd.rep) used[idx] <= 1'b0;
          end else if (src_dist < limit) begin
            // sorted insert, nearest first
            for (int j = 0; j < VOICES; j++) begin
              if (lt[j] && (j == 0 || !lt[j == 0 ? 0 : j-1])) begin
                cand_dist[j]  <= src_dist;
                cand_slot[j]  <= idx;
                cand_valid[j] <= 1'b1;
              end else if (j > 0 && lt[j == 0 ? 0 : j-1]) begin
                cand_dist[j]  <= cand_dist[j == 0 ? 0 : j-1];
                cand_slot[j]  <= cand_slot[j == 0 ? 0 : j-1];
                cand_valid[j] <= cand_valid[j == 0 ? 0 : j-1];
              end
            end
          end
          if (!(bound[idx] && busy[dyn_rd.chan]) || can_emit) begin
            if (idx == SLOT_W'(SRC_SLOTS - 1)) begin
              ch    <= '0;
              k     <= '0;
              state <= S_S_CHK;
            end else begin
              idx   <= idx + SLOT_W'(1);
              state <= S_U_RD;
            end
          end
        end

        // pair free channels with candidates in order
        S_S_CHK: begin
          if (ch == VCNT_W'(VOICES)) begin
            state <= S_DONE;
          end else if (busy[ch[CHAN_W-1:0]]) begin
            ch <= ch + VCNT_W'(1);
          end else if (k < VCNT_W'(VOICES) && cand_valid[k[CHAN_W-1:0]]) begin
            idx   <= cand_slot[k[CHAN_W-1:0]];
            state <= S_S_RD;
          end else begin
            state <= S_DONE;
          end
        end

        S_S_RD: state <= S_S_EMIT;

        S_S_EMIT: begin
          if (can_emit) begin
            bound[idx] <= 1'b1;
            m_tlast  <= 1'b0;
            m_tuser  <= KIND_START;
            o_slot   <= idx;
            o_chan   <= ch[CHAN_W-1:0];
            o_vol    <= dyn_rd.vol;
            o_sound  <= src_rd.sound;
            k        <= k + VCNT_W'(1);
            ch       <= ch + VCNT_W'(1);
            state    <= S_S_CHK;
          end
        end

        S_DONE: begin
          if (can_emit) begin
            m_tlast  <= 1'b1;
            m_tuser  <= KIND_DONE;
            o_slot   <= '0;
            o_chan   <= '0;
            o_vol    <= '0;
            o_sound  <= '0;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/nsva_dist.sv =====
module nsva_dist
  import nsva_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [SQ_W-1:0]         sq,
  input  logic [RANGE_W-1:0]      audible_range,
  output logic                    done,
  output logic [DIST_W-1:0]       distance,
  output logic signed [VOL_W-1:0] vol
);

  localparam int N_W   = SQ_W + 16;
  localparam int QB    = 12;
  localparam int NUM_W = DIST_W + QB;
  localparam logic [QB-1:0] ATTEN = 12'd3000;
  localparam logic signed [VOL_W-1:0] VOL_FLOOR = -13'sd2999;

  typedef enum logic [2:0] {D_IDLE, D_SQRT, D_MUL, D_DIV, D_FIN} dstate_t;

  dstate_t          state;
  logic [N_W-1:0]   n;
  logic [N_W-1:0]   root;
  logic [N_W-1:0]   bitv;
  logic [N_W:0]     trial;
  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dv;
  logic [QB-1:0]    quo;
  logic [3:0]       cnt;
  logic             over;
  logic [DIST_W-1:0] q;

  assign q     = {({1'b0, audible_range} + 17'd1), 8'd0};
  assign trial = {1'b0, root} + {1'b0, bitv};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == D_FIN);
      case (state)
        D_IDLE: begin
          if (start) begin
            n     <= {sq, 16'd0};
            root  <= '0;
            bitv  <= {2'b01, {(N_W-2){1'b0}}};
            state <= D_SQRT;
          end
        end
        D_SQRT: begin
          // one root bit per cycle
          if ({1'b0, n} >= trial) begin
            n    <= n - trial[N_W-1:0];
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv[0]) state <= D_MUL;
        end
        D_MUL: begin
          distance <= root[DIST_W-1:0];
          rem   <= NUM_W'(ATTEN) * NUM_W'(root[DIST_W-1:0]);
          over  <= root[DIST_W-1:0] > q;
          dv    <= NUM_W'({q, 11'd0});
          quo   <= '0;
          cnt   <= 4'd11;
          state <= D_DIV;
        end
        D_DIV: begin
          if (rem >= dv) begin
            rem <= rem - dv;
            quo <= {quo[QB-2:0], 1'b1};
          end else begin
            quo <= {quo[QB-2:0], 1'b0};
          end
          dv  <= dv >> 1;
          cnt <= cnt - 4'd1;
          if (cnt == 4'd0) state <= D_FIN;
        end
        D_FIN: begin
          vol   <= over ? VOL_FLOOR : -$signed({1'b0, quo});
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule
